### rtl/spherical_texture_lookup_assert.svh
// ----------------------------------------------------------------------------
// Spherical texture lookup assertion macros
// Clocked, reset-qualified assertion shorthands shared by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_TEXTURE_LOOKUP_ASSERT_SVH
`define SPHERICAL_TEXTURE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Types, constants and the arctangent table of the spherical texture lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package stl_pkg;
	localparam int CORDIC_STEPS = 28;
	localparam int SQRT_STEPS   = 15;
	localparam int ANG_W        = 34;
	localparam int SQ_W         = 29;
	localparam logic [7:0] CFG_WIDTH  = 8'd0;
	localparam logic [7:0] CFG_HEIGHT = 8'd1;
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// atan(2^-i) in turns scaled by 2^32
	function automatic logic [31:0] turn_entry(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;   1: t = 32'd316933406;
			2: t = 32'd167458907;   3: t = 32'd85004756;
			4: t = 32'd42667331;    5: t = 32'd21354465;
			6: t = 32'd10679838;    7: t = 32'd5340245;
			8: t = 32'd2670163;     9: t = 32'd1335087;
			10: t = 32'd667544;     11: t = 32'd333772;
			12: t = 32'd166886;     13: t = 32'd83443;
			14: t = 32'd41722;      15: t = 32'd20861;
			16: t = 32'd10430;      17: t = 32'd5215;
			18: t = 32'd2608;       19: t = 32'd1304;
			20: t = 32'd652;        21: t = 32'd326;
			22: t = 32'd163;        23: t = 32'd81;
			24: t = 32'd41;         25: t = 32'd20;
			26: t = 32'd10;         27: t = 32'd5;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

	// word fields carried beside the longitude vector and square root
	typedef struct packed {
		logic              func;
		logic              xz_zero;
		logic signed [ANG_W-1:0] u_px;
		logic signed [ANG_W-1:0] u_py;
		logic              z_neg;
		logic signed [15:0] s;
		logic [15:0]       addr;
		logic [23:0]       rgb;
	} isq_side_t;

	// word fields carried beside the latitude vector
	typedef struct packed {
		logic        func;
		logic [15:0] addr;
		logic [23:0] rgb;
	} vec_side_t;
endpackage
`default_nettype wire

### rtl/stl_ram.sv
// ----------------------------------------------------------------------------
// stl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/stl_isqrt.sv
// ----------------------------------------------------------------------------
// stl_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_isqrt #(
	parameter int SIDE_W = 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [stl_pkg::SQ_W-1:0] in_n,
	input  wire logic [SIDE_W-1:0]        in_side,
	output logic                          out_valid,
	output logic      [stl_pkg::SQ_W-1:0] out_root,
	output logic      [SIDE_W-1:0]        out_side
);
	localparam int N = stl_pkg::SQRT_STEPS;
	localparam int W = stl_pkg::SQ_W;

	logic         valid_s [N+1];
	logic [W-1:0] n_s     [N+1];
	logic [W-1:0] r_s     [N+1];
	logic [SIDE_W-1:0] side_s [N+1];

	assign valid_s[0] = in_valid;
	assign n_s[0]     = in_n;
	assign r_s[0]     = '0;
	assign side_s[0]  = in_side;

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2 * j);
		logic [W-1:0] trial;
		assign trial = r_s[j] + BIT;

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		// take one root bit
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_s[j];
				if (n_s[j] >= trial) begin
					n_s[j+1] <= n_s[j] - trial;
					r_s[j+1] <= (r_s[j] >> 1) + BIT;
				end else begin
					n_s[j+1] <= n_s[j];
					r_s[j+1] <= r_s[j] >> 1;
				end
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_root  = r_s[N];
	assign out_side  = side_s[N];
endmodule
`default_nettype wire

### rtl/stl_cordic.sv
// ----------------------------------------------------------------------------
// stl_cordic
// Pipelined CORDIC vectoring, one rotation per stage, angle in turns.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_cordic #(
	parameter int SIDE_W = 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire logic signed [stl_pkg::ANG_W-1:0] in_px,
	input  wire logic signed [stl_pkg::ANG_W-1:0] in_py,
	input  wire logic signed [stl_pkg::ANG_W-1:0] in_acc,
	input  wire logic        [SIDE_W-1:0]         in_side,
	output logic                                  out_valid,
	output logic signed      [stl_pkg::ANG_W-1:0] out_acc,
	output logic             [SIDE_W-1:0]         out_side
);
	localparam int N = stl_pkg::CORDIC_STEPS;
	localparam int W = stl_pkg::ANG_W;

	logic                valid_s [N+1];
	logic signed [W-1:0] px_s    [N+1];
	logic signed [W-1:0] py_s    [N+1];
	logic signed [W-1:0] acc_s   [N+1];
	logic [SIDE_W-1:0]   side_s  [N+1];

	assign valid_s[0] = in_valid;
	assign px_s[0]    = in_px;
	assign py_s[0]    = in_py;
	assign acc_s[0]   = in_acc;
	assign side_s[0]  = in_side;

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [W-1:0] ANG = W'(stl_pkg::turn_entry(i));
		logic signed [W-1:0] dx, dy;
		assign dx = py_s[i] >>> i;
		assign dy = px_s[i] >>> i;

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (py_s[i] > 0) begin
					px_s[i+1]  <= px_s[i] + dx;
					py_s[i+1]  <= py_s[i] - dy;
					acc_s[i+1] <= acc_s[i] + ANG;
				end else begin
					px_s[i+1]  <= px_s[i] - dx;
					py_s[i+1]  <= py_s[i] + dy;
					acc_s[i+1] <= acc_s[i] - ANG;
				end
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_acc   = acc_s[N];
	assign out_side  = side_s[N];
endmodule
`default_nettype wire

### rtl/spherical_texture_lookup.sv
// ----------------------------------------------------------------------------
// spherical_texture_lookup
// Maps a unit-sphere hit to (u, v), scales to a texel and fetches its RGB.
// ----------------------------------------------------------------------------
//  channel | signals                                  | flow
//  --------+------------------------------------------+-----------------------
//  req     | req_valid, req_stall, func..texel_b      | lookup or texel write
//  rsp     | rsp_valid, rsp_stall, out_r..in_range    | one word per lookup
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | texture width/height
//
//  One word enters per cycle while no result is stalled; it passes the
//  capture stage, the square-root stages, the CORDIC stages, then scaling,
//  index and RAM read.
//  Writes travel the same pipe and update the RAM in the read stage, so order
//  is kept. A stalled result freezes the whole pipe; req_stall follows it.
//  Reset clears valid bits and sets width and height to 256; the texel RAM
//  is not cleared.
`default_nettype none
`include "spherical_texture_lookup_assert.svh"
module spherical_texture_lookup #(
	parameter int TEX_DEPTH = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               func,
	input  wire logic signed [15:0] hit_x,
	input  wire logic signed [15:0] hit_z,
	input  wire logic signed [15:0] sin_lat,
	input  wire logic [15:0]        texel_addr,
	input  wire logic [7:0]         texel_r,
	input  wire logic [7:0]         texel_g,
	input  wire logic [7:0]         texel_b,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [7:0]              out_r,
	output logic [7:0]              out_g,
	output logic [7:0]              out_b,
	output logic                    in_range,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [8:0]         cfg_data
);
	localparam int AW = $clog2(TEX_DEPTH);
	localparam int AN = stl_pkg::ANG_W;
	localparam logic [31:0] DEPTH32 = 32'(TEX_DEPTH);

	logic advance;
	logic [8:0] width_q, height_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == stl_pkg::CFG_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == stl_pkg::CFG_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// whole pipe holds while a result is stalled
	assign advance   = !(rsp_valid && rsp_stall);
	assign req_stall = !advance;

	// stage 1: capture the word
	logic valid_s1, func_s1;
	logic signed [15:0] x_s1, z_s1, s_s1;
	logic [15:0] addr_s1;
	logic [23:0] rgb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1 <= func;
			x_s1    <= hit_x;
			z_s1    <= hit_z;
			s_s1    <= sin_lat;
			addr_s1 <= texel_addr;
			rgb_s1  <= {texel_r, texel_g, texel_b};
		end
	end

	// clamp sine, form 2^28 - s^2 and the longitude vector
	logic signed [15:0] s_clamp;
	logic signed [31:0] s_sq;
	logic [stl_pkg::SQ_W-1:0] n_in;
	logic signed [AN-1:0] xe, ze;
	stl_pkg::isq_side_t isq_in, isq_out;

	always_comb begin
		if (s_s1 > 16'sd16384) begin
			s_clamp = 16'sd16384;
		end else if (s_s1 < -16'sd16384) begin
			s_clamp = -16'sd16384;
		end else begin
			s_clamp = s_s1;
		end
		s_sq = s_clamp * s_clamp;
		n_in = stl_pkg::SQ_W'(29'd268435456 - stl_pkg::SQ_W'(s_sq));
		xe   = AN'(x_s1) <<< 15;
		ze   = AN'(z_s1) <<< 15;
		isq_in.func    = func_s1;
		isq_in.xz_zero = (x_s1 == 16'sd0) && (z_s1 == 16'sd0);
		isq_in.z_neg   = z_s1[15];
		isq_in.u_px    = z_s1[15] ? -ze : ze;
		isq_in.u_py    = z_s1[15] ? -xe : xe;
		isq_in.s       = s_clamp;
		isq_in.addr    = addr_s1;
		isq_in.rgb     = rgb_s1;
	end

	logic isq_valid;
	logic [stl_pkg::SQ_W-1:0] root;

	stl_isqrt #(.SIDE_W($bits(stl_pkg::isq_side_t))) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(advance),
		.in_valid(valid_s1), .in_n(n_in), .in_side(isq_in),
		.out_valid(isq_valid), .out_root(root), .out_side(isq_out)
	);

	// latitude and longitude CORDICs side by side
	stl_pkg::vec_side_t vside_in, vside_out;
	logic v_valid, u_valid, u_zero;
	logic signed [AN-1:0] v_acc, u_acc;

	assign vside_in.func = isq_out.func;
	assign vside_in.addr = isq_out.addr;
	assign vside_in.rgb  = isq_out.rgb;

	stl_cordic #(.SIDE_W($bits(stl_pkg::vec_side_t))) u_cordic_v (
		.clk(clk), .arst_n(arst_n), .en(advance), .in_valid(isq_valid),
		.in_px(AN'(root) <<< 15), .in_py(AN'(isq_out.s) <<< 15),
		.in_acc('0), .in_side(vside_in),
		.out_valid(v_valid), .out_acc(v_acc), .out_side(vside_out)
	);

	stl_cordic #(.SIDE_W(1)) u_cordic_u (
		.clk(clk), .arst_n(arst_n), .en(advance), .in_valid(isq_valid),
		.in_px(isq_out.u_px), .in_py(isq_out.u_py),
		.in_acc(isq_out.z_neg ? AN'(34'sd2147483648) : AN'(0)),
		.in_side(isq_out.xz_zero),
		.out_valid(u_valid), .out_acc(u_acc), .out_side(u_zero)
	);

	// u and v in 16-bit fraction, scaled by width and height
	logic signed [AN-1:0] u_neg;
	logic signed [AN+1:0] v32;
	logic [15:0] u_q16;
	logic [16:0] v_q17;

	always_comb begin
		u_neg = -u_acc;
		u_q16 = u_zero ? 16'd0 : u_neg[31:16];
		v32   = ((AN+2)'(v_acc) <<< 1) + (AN+2)'(36'sd2147483648);
		if (v32 < 0) begin
			v_q17 = 17'd0;
		end else if (v32 > (AN+2)'(36'sd4294967296)) begin
			v_q17 = 17'd65536;
		end else begin
			v_q17 = v32[32:16];
		end
	end

	logic valid_s2, func_s2;
	logic [24:0] mu_s2;
	logic [25:0] mv_s2;
	logic [15:0] addr_s2;
	logic [23:0] rgb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= v_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s2 <= vside_out.func;
			mu_s2   <= 25'(u_q16 * width_q);
			mv_s2   <= 26'(v_q17 * height_q);
			addr_s2 <= vside_out.addr;
			rgb_s2  <= vside_out.rgb;
		end
	end

	// column and row, with the top row wrapping to zero
	logic [9:0] row_raw;
	logic [8:0] row_wrap;

	always_comb begin
		row_raw = mv_s2[25:16];
		if (row_raw >= 10'(height_q)) begin
			row_wrap = 9'(row_raw - 10'(height_q));
		end else begin
			row_wrap = row_raw[8:0];
		end
	end

	logic valid_s3, func_s3;
	logic [8:0] col_s3, row_s3;
	logic [15:0] addr_s3;
	logic [23:0] rgb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s3 <= func_s2;
			col_s3  <= mu_s2[24:16];
			row_s3  <= row_wrap;
			addr_s3 <= addr_s2;
			rgb_s3  <= rgb_s2;
		end
	end

	// texel index, range check and RAM access
	logic [17:0] idx;
	logic [31:0] idx32, wa32;
	logic lookup_ok, ram_we;

	always_comb begin
		idx       = 18'(row_s3 * width_q) + 18'(col_s3);
		idx32     = 32'(idx);
		wa32      = 32'(addr_s3);
		lookup_ok = (width_q != 9'd0) && (height_q != 9'd0) && (idx32 < DEPTH32);
		ram_we    = advance && valid_s3 && (func_s3 == stl_pkg::FUNC_WRITE)
		            && (wa32 < DEPTH32);
	end

	logic [23:0] texel;

	stl_ram #(.WIDTH(24), .DEPTH(TEX_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(wa32[AW-1:0]), .wdata(rgb_s3),
		.re(advance), .raddr(idx32[AW-1:0]), .rdata(texel)
	);

	logic valid_s4, func_s4, ok_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s4 <= func_s3;
			ok_s4   <= lookup_ok;
		end
	end

	// drive result word, black when out of range
	assign rsp_valid = valid_s4 && (func_s4 == stl_pkg::FUNC_LOOKUP);
	assign in_range  = ok_s4;
	assign out_r     = ok_s4 ? texel[23:16] : 8'd0;
	assign out_g     = ok_s4 ? texel[15:8]  : 8'd0;
	assign out_b     = ok_s4 ? texel[7:0]   : 8'd0;

	`STL_ASSERT_NOW(a_cordic_aligned, 1'b1, u_valid == v_valid, "CORDIC lanes out of step")
	`STL_ASSERT_NOW(a_write_silent, valid_s4 && (func_s4 == stl_pkg::FUNC_WRITE), !rsp_valid, "write produced a result")
	`STL_ASSERT_NOW(a_col_bound, valid_s3 && (width_q != 9'd0), col_s3 < width_q, "column beyond width")
	`STL_ASSERT_NOW(a_row_bound, valid_s3 && (height_q != 9'd0), row_s3 < height_q, "row beyond height")
	`STL_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && valid_s4, "stalled pipe moved")
endmodule
`default_nettype wire

### test/spherical_texture_lookup_tb.sv
// ----------------------------------------------------------------------------
// spherical_texture_lookup_tb
// Self-checking bench: drives texel writes and sphere lookups with random
// gaps and result stalls, predicts every fetched texel with a CORDIC model of
// its own, and walks several texture sizes, including zero and oversize ones.
// ----------------------------------------------------------------------------
module spherical_texture_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 65536;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic        func;
		logic [15:0] x;
		logic [15:0] z;
		logic [15:0] s;
		logic [15:0] addr;
		logic [23:0] rgb;
	} req_word_t;

	typedef struct {
		logic [23:0] rgb;
		logic        ok;
	} texel_word_t;

	// directed row: typed result only where it is obvious
	typedef struct {
		req_word_t   w;
		bit          typed;
		texel_word_t res;
	} dir_row_t;

	localparam longint ATAN_TURNS [28] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};

	logic clk = 1'b0, arst_n = 1'b0;
	logic req_valid = 1'b0, rsp_stall = 1'b0;
	logic func = 1'b0;
	logic signed [15:0] hit_x = '0, hit_z = '0, sin_lat = '0;
	logic [15:0] texel_addr = '0;
	logic [7:0] texel_r = '0, texel_g = '0, texel_b = '0;
	logic cfg_valid = 1'b0;
	logic [7:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;
	wire req_stall, rsp_valid, cfg_ready, in_range;
	wire [7:0] out_r, out_g, out_b;

	spherical_texture_lookup u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .hit_x(hit_x), .hit_z(hit_z), .sin_lat(sin_lat),
		.texel_addr(texel_addr), .texel_r(texel_r), .texel_g(texel_g),
		.texel_b(texel_b),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.out_r(out_r), .out_g(out_g), .out_b(out_b), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [23:0] texels [STORE_DEPTH];
	bit written [STORE_DEPTH];
	logic [8:0] cur_w = 9'd256, cur_h = 9'd256;
	texel_word_t pending_texels[$];
	texel_word_t typed_q[$];
	bit typed_flag_q[$];
	int fails = 0, lookups = 0, hits = 0, writes = 0;
	bit stim_done = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	// angle of (px, py), px >= 0, in turns scaled by 2^32
	function automatic longint vector_turns(input longint px, input longint py);
		longint acc, dx, dy;
		acc = 0;
		for (int i = 0; i < 28; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (py > 0) begin
				px += dx; py -= dy; acc += ATAN_TURNS[i];
			end else begin
				px -= dx; py += dy; acc -= ATAN_TURNS[i];
			end
		end
		return acc;
	endfunction

	function automatic int unsigned int_root(input int unsigned n);
		int unsigned r, b;
		r = 0;
		b = 32'h4000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// map a hit to its texel index under the given size
	function automatic void texel_index(input logic [15:0] hx, input logic [15:0] hz,
			input logic [15:0] sl, input logic [8:0] w9, input logic [8:0] h9,
			output bit ok, output longint idx);
		longint x, z, s, theta, v32, uq, vq, col, row, w, h;
		int unsigned c;
		x = longint'($signed(hx));
		z = longint'($signed(hz));
		s = longint'($signed(sl));
		w = w9;
		h = h9;
		idx = 0;
		if (x == 0 && z == 0) theta = 0;
		else if (z < 0) theta = 64'sd2147483648 + vector_turns(-z * 32768, -x * 32768);
		else theta = vector_turns(z * 32768, x * 32768);
		uq = ((0 - theta) & 64'hFFFF_FFFF) >> 16;
		if (s > 16384) s = 16384;
		if (s < -16384) s = -16384;
		c = int_root(32'(268435456 - s * s));
		v32 = 2 * vector_turns(longint'(c) * 32768, s * 32768) + 64'sd2147483648;
		if (v32 < 0) v32 = 0;
		if (v32 > 64'sd4294967296) v32 = 64'sd4294967296;
		vq = v32 >> 16;
		ok = (w != 0) && (h != 0);
		if (ok) begin
			col = (uq * w) >> 16;
			row = (vq * h) >> 16;
			if (col >= w) col -= w;
			if (row >= h) row -= h;
			idx = row * w + col;
			ok = idx < w * h && idx < STORE_DEPTH;
		end
	endfunction

	// one word over the request channel
	task automatic send_word(input req_word_t w);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		func <= w.func;
		hit_x <= w.x;
		hit_z <= w.z;
		sin_lat <= w.s;
		texel_addr <= w.addr;
		{texel_r, texel_g, texel_b} <= w.rgb;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic send_write(input logic [15:0] a, input logic [23:0] rgb);
		req_word_t w;
		w = '{stl_pkg::FUNC_WRITE, $urandom, $urandom, $urandom, a, rgb};
		written[a] = 1'b1;
		send_word(w);
	endtask

	// lookup, loading the target texel first if it was never written
	task automatic send_lookup(input req_word_t w, input bit typed, input texel_word_t res);
		bit ok;
		longint idx;
		w.func = stl_pkg::FUNC_LOOKUP;
		texel_index(w.x, w.z, w.s, cur_w, cur_h, ok, idx);
		if (ok && !written[idx]) send_write(16'(idx), 24'($urandom));
		typed_flag_q.push_back(typed);
		if (typed) typed_q.push_back(res);
		send_word(w);
	endtask

	// drop valid, then let every word in flight drain
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_texels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] index, input logic [8:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (index == stl_pkg::CFG_WIDTH) cur_w = value;
		else cur_h = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] coord_pick();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] sine_pick();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	// random result stalls
	initial begin
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
						: $urandom_range(1, 3)) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end
		end
	end

	// accept side: update store, predict lookups
	always @(posedge clk) begin
		bit ok;
		longint idx;
		texel_word_t e;
		if (arst_n && req_valid && !req_stall) begin
			if (func == stl_pkg::FUNC_WRITE) begin
				texels[texel_addr] = {texel_r, texel_g, texel_b};
				writes++;
			end else begin
				texel_index(hit_x, hit_z, sin_lat, cur_w, cur_h, ok, idx);
				e.ok = ok;
				e.rgb = ok ? texels[idx] : 24'h0;
				if (typed_flag_q.pop_front()) e = typed_q.pop_front();
				pending_texels.push_back(e);
				lookups++;
			end
		end
	end

	// result side: compare with oldest expectation
	always @(posedge clk) begin
		texel_word_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_texels.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				e = pending_texels.pop_front();
				if (in_range) hits++;
				if (out_r !== e.rgb[23:16]) begin
					$error("out_r expected %0h actual %0h", e.rgb[23:16], out_r); fails++;
				end
				if (out_g !== e.rgb[15:8]) begin
					$error("out_g expected %0h actual %0h", e.rgb[15:8], out_g); fails++;
				end
				if (out_b !== e.rgb[7:0]) begin
					$error("out_b expected %0h actual %0h", e.rgb[7:0], out_b); fails++;
				end
				if (in_range !== e.ok) begin
					$error("in_range expected %0b actual %0b", e.ok, in_range); fails++;
				end
			end
		end
	end

	// directed table, then random phases over several texture sizes
	initial begin
		dir_row_t rows[$];
		texel_word_t none;
		req_word_t w;
		logic [8:0] sizes [10][2] = '{
			'{9'd256, 9'd256}, '{9'd1, 9'd1}, '{9'd17, 9'd3}, '{9'd0, 9'd5},
			'{9'd300, 9'd300}, '{9'd511, 9'd511}, '{9'd256, 9'd1}, '{9'd1, 9'd256},
			'{9'd100, 9'd200}, '{9'd5, 9'd0}};
		none = '{24'h0, 1'b0};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extremes at reset size
		rows.push_back('{'{stl_pkg::FUNC_WRITE, 0, 0, 0, 16'h0000, 24'hFF0080}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_WRITE, 0, 0, 0, 16'hFFFF, 24'h7F01FE}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 0, 0, -16'sd16384, 0, 0}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'h7FFF, 16'h7FFF, 16'sd16384, 0, 0},
			0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'h8000, 16'h8000, 16'h7FFF, 0, 0}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'h8000, 16'h0000, 16'h8000, 0, 0}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'h0000, 16'h8000, 16'h0000, 0, 0}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'h7FFF, 16'h0000, 16'h4001, 0, 0}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'hFFFF, 16'h8000, 16'hBFFF, 0, 0}, 0, none});
		rows.push_back('{'{stl_pkg::FUNC_LOOKUP, 16'h0001, 16'hFFFF, 16'h0001, 0, 0}, 0, none});
		foreach (rows[i]) begin
			if (rows[i].w.func == stl_pkg::FUNC_WRITE) send_write(rows[i].w.addr, rows[i].w.rgb);
			else send_lookup(rows[i].w, rows[i].typed, rows[i].res);
		end
		// zero width: always black and out of range
		wait_idle();
		write_reg(stl_pkg::CFG_WIDTH, 9'd0);
		send_lookup('{stl_pkg::FUNC_LOOKUP, 16'h1234, 16'h8000, 16'h2000, 0, 0}, 1, none);
		send_lookup('{stl_pkg::FUNC_LOOKUP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0}, 1, none);
		send_lookup('{stl_pkg::FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h8000, 0, 0}, 1, none);

		for (int p = 0; p < 10; p++) begin
			wait_idle();
			write_reg(stl_pkg::CFG_WIDTH, sizes[p][0]);
			write_reg(stl_pkg::CFG_HEIGHT, sizes[p][1]);
			repeat (185) begin
				w = '{stl_pkg::FUNC_LOOKUP, coord_pick(), coord_pick(), sine_pick(),
					16'($urandom), 24'($urandom)};
				if ($urandom_range(0, 3) == 0) send_write(w.addr, w.rgb);
				else send_lookup(w, 0, none);
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;
		stim_done = 1'b1;
		wait_idle();
		$display("covered %0d lookups (%0d in range) and %0d texel writes over 10 sizes",
			lookups, hits, writes);
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
